// ===== sv/mean_nearest_neighbor_sigma_top_assert.svh =====
// Assertion macros for the mean nearest-neighbor sigma block.
`ifndef MEAN_NEAREST_NEIGHBOR_SIGMA_TOP_ASSERT_SVH
`define MEAN_NEAREST_NEIGHBOR_SIGMA_TOP_ASSERT_SVH
// Asserts that an antecedent implies a consequent in the same cycle.
`define MNNS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Asserts that an antecedent implies a consequent in the next cycle.
`define MNNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/mnns_pkg.sv =====
// Package with constants and types for the mean nearest-neighbor sigma block.
package mnns_pkg;
    localparam int unsigned MAX_POINTS_DEF    = 4096;
    localparam int unsigned COORD_BITS_DEF    = 16;
    localparam int unsigned SAMPLE_TARGET_DEF = 1000;
    localparam logic [47:0] DEFAULT_SIGMA     = 48'd6553600;
    localparam logic [47:0] SIGMA_MAX         = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] COORD_SCALE_RST   = 32'd65536;
    localparam logic [0:0]  REG_COORD_SCALE   = 1'b0;
    localparam logic [0:0]  REG_MIN_SIGMA     = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FEW       = 2'd1,
        ST_NO_DIST   = 2'd2,
        ST_THRESHOLD = 2'd3
    } status_t;

    typedef struct packed {
        logic start;
        logic busy;
    } div_ctrl_t;
endpackage

// ===== sv/mnns_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module mnns_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/mnns_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all divisions.
module mnns_div
    import mnns_pkg::*;
#(
    parameter int unsigned NW = 80,
    parameter int unsigned DW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  div_ctrl_t     ctrl_in,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem
);
    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    assign trial = {r_reg[DW-1:0], q_reg[NW-1]};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            done    <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done <= 1'b0;
            if (ctrl_in.start) begin
                q_reg   <= num;
                r_reg   <= '0;
                d_reg   <= den;
                cnt_reg <= CW'(NW);
                run_reg <= 1'b1;
            end else if (run_reg) begin
                if (trial >= {1'b0, d_reg}) begin
                    r_reg <= diff;
                    q_reg <= {q_reg[NW-2:0], 1'b1};
                end else begin
                    r_reg <= trial;
                    q_reg <= {q_reg[NW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    assign quo = q_reg;
    assign rem = r_reg[DW-1:0];
endmodule

// ===== sv/mean_nearest_neighbor_sigma_top.sv =====
// Top level of the mean nearest-neighbor sigma block: point store and sequencer.
//   channel | dir | fields (tdata low bit up)                       | handshake
//   s_      | in  | point_row[15:0] point_col[31:16] point_valid[32]  | tvalid/tready
//           |     | last_point on s_tlast                              |
//   m_      | out | sigma[47:0] status[49:48] sample_count[62:50]     | tvalid/tready
//   cfg     | in  | cfg_we, cfg_index, cfg_wdata                       | write only
// After the last point, a point count above the sample target first has the
// stride found by repeated subtraction of the target, then the nested scan
// through the point RAMs runs, followed by division, square root and scaling.
// Reset is synchronous; the point RAMs are not cleared.  The result waits in
// an output register, and the block takes no request until it is delivered.
module mean_nearest_neighbor_sigma_top
    import mnns_pkg::*;
#(
    parameter int unsigned MAX_POINTS    = MAX_POINTS_DEF,
    parameter int unsigned COORD_BITS    = COORD_BITS_DEF,
    parameter int unsigned SAMPLE_TARGET = SAMPLE_TARGET_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // point_row, point_col, point_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // sigma, status, sample_count
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);
`include "mean_nearest_neighbor_sigma_top_assert.svh"

    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned NB = $clog2(MAX_POINTS + 1);
    localparam int unsigned SQ = 2 * COORD_BITS + 1;
    localparam int unsigned SW = SQ + NB;
    localparam int unsigned NW = 80;

    typedef enum logic [3:0] {
        S_LOAD, S_STEP, S_OUTER, S_RD_I, S_LAT_I, S_INNER, S_ADD,
        S_MEAN, S_FRAC, S_SQRT, S_SCALE, S_OUT
    } state_t;

    state_t state_reg;
    logic [31:0] coord_scale_reg, min_sigma_reg;
    logic [NB-1:0] count_reg, i_reg, j_reg, step_reg, contrib_reg;
    logic [SW-1:0] sum_reg;
    logic [COORD_BITS-1:0] ri_reg, ci_reg;
    logic [SQ-1:0] best_reg;
    logic seen_reg, cmp_valid_reg, cmp_skip_reg;
    logic [63:0] q_reg;
    logic [63:0] rad_reg, sq_rem_reg;
    logic [39:0] root_reg;
    logic [6:0] sqcnt_reg;
    logic [47:0] sigma_reg;
    status_t status_reg;
    logic [12:0] sample_reg;
    logic phase_reg;

    logic [COORD_BITS-1:0] row_rd, col_rd, in_row, in_col;
    logic [AW-1:0] raddr;
    logic st_we;
    logic in_acc;
    logic [COORD_BITS-1:0] dr, dc;
    logic [2*COORD_BITS-1:0] dr2, dc2;
    logic [SQ-1:0] pair_dist;

    div_ctrl_t dctl;
    logic [NW-1:0] dnum, dquo;
    logic [31:0] dden, drem;
    logic ddone;

    assign in_acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_LOAD);
    assign in_row = s_tdata[COORD_BITS-1:0];
    assign in_col = s_tdata[16 +: COORD_BITS];
    assign st_we = in_acc && s_tdata[32] && (count_reg < NB'(MAX_POINTS));

    mnns_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_row (
        .aclk(aclk), .we(st_we), .waddr(count_reg[AW-1:0]), .wdata(in_row),
        .raddr(raddr), .rdata(row_rd));
    mnns_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_col (
        .aclk(aclk), .we(st_we), .waddr(count_reg[AW-1:0]), .wdata(in_col),
        .raddr(raddr), .rdata(col_rd));

    mnns_div #(.NW(NW), .DW(32)) u_div (
        .aclk(aclk), .aresetn(aresetn), .ctrl_in(dctl), .num(dnum), .den(dden),
        .done(ddone), .quo(dquo), .rem(drem));

    assign raddr = (state_reg == S_RD_I) ? i_reg[AW-1:0] : j_reg[AW-1:0];
    assign dr = (row_rd > ri_reg) ? row_rd - ri_reg : ri_reg - row_rd;
    assign dc = (col_rd > ci_reg) ? col_rd - ci_reg : ci_reg - col_rd;
    assign dr2 = dr * dr;
    assign dc2 = dc * dc;
    assign pair_dist = SQ'(dr2) + SQ'(dc2);

    logic [63:0] sq_trial;
    logic [63:0] sq_sub;
    logic [1:0]  sq_pair;
    assign sq_pair  = q_reg[63:62];
    assign sq_trial = {sq_rem_reg[61:0], sq_pair};
    assign sq_sub   = {22'd0, root_reg, 2'b01};

    always_comb begin
        dctl = '0;
        dnum = '0;
        dden = 32'd1;
        unique case (state_reg)
            S_MEAN: begin
                dctl.start = 1'b1;
                dnum = NW'(sum_reg);
                dden = 32'(contrib_reg);
            end
            S_FRAC: begin
                dctl.start = ddone && !phase_reg;
                dnum = NW'({drem, 32'd0});
                dden = 32'(contrib_reg);
            end
            S_SCALE: begin
                dctl.start = !phase_reg;
                dnum = NW'({root_reg, 16'd0});
                dden = (coord_scale_reg == 32'd0) ? 32'd1 : coord_scale_reg;
            end
            default: ;
        endcase
        dctl.busy = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_LOAD;
            coord_scale_reg <= COORD_SCALE_RST;
            min_sigma_reg   <= '0;
            count_reg       <= '0;
            m_tvalid        <= 1'b0;
            phase_reg       <= 1'b0;
            cmp_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_COORD_SCALE) coord_scale_reg <= cfg_wdata;
                else min_sigma_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_LOAD: begin
                    if (in_acc) begin
                        if (st_we) count_reg <= count_reg + 1'b1;
                        if (s_tlast) state_reg <= S_STEP;
                    end
                end
                S_STEP: begin
                    sum_reg     <= '0;
                    contrib_reg <= '0;
                    i_reg       <= '0;
                    if (count_reg < NB'(2)) begin
                        sigma_reg  <= DEFAULT_SIGMA;
                        status_reg <= ST_FEW;
                        sample_reg <= '0;
                        state_reg  <= S_OUT;
                    end else if (count_reg <= NB'(SAMPLE_TARGET)) begin
                        step_reg  <= NB'(1);
                        state_reg <= S_OUTER;
                    end else if (!phase_reg) begin
                        j_reg     <= count_reg - NB'(SAMPLE_TARGET);
                        step_reg  <= NB'(1);
                        phase_reg <= 1'b1;
                    end else if (j_reg >= NB'(SAMPLE_TARGET)) begin
                        j_reg    <= j_reg - NB'(SAMPLE_TARGET);
                        step_reg <= step_reg + 1'b1;
                    end else begin
                        state_reg <= S_OUTER;
                    end
                end
                S_OUTER: begin
                    phase_reg <= 1'b0;
                    if (i_reg >= count_reg) begin
                        if (contrib_reg == '0) begin
                            sigma_reg  <= DEFAULT_SIGMA;
                            status_reg <= ST_NO_DIST;
                            sample_reg <= '0;
                            state_reg  <= S_OUT;
                        end else begin
                            state_reg <= S_MEAN;
                        end
                    end else begin
                        state_reg <= S_RD_I;
                    end
                end
                S_RD_I: state_reg <= S_LAT_I;
                S_LAT_I: begin
                    ri_reg        <= row_rd;
                    ci_reg        <= col_rd;
                    seen_reg      <= 1'b0;
                    j_reg         <= '0;
                    cmp_valid_reg <= 1'b0;
                    state_reg     <= S_INNER;
                end
                S_INNER: begin
                    // j_reg addresses the RAM; its data is compared in the next cycle.
                    if (cmp_valid_reg && !cmp_skip_reg) begin
                        if (!seen_reg || pair_dist < best_reg) best_reg <= pair_dist;
                        seen_reg <= 1'b1;
                    end
                    cmp_skip_reg  <= (j_reg == i_reg);
                    cmp_valid_reg <= (j_reg < count_reg);
                    if (j_reg < count_reg) j_reg <= j_reg + 1'b1;
                    else if (!cmp_valid_reg) state_reg <= S_ADD;
                end
                S_ADD: begin
                    if (seen_reg && best_reg != '0) begin
                        sum_reg     <= sum_reg + SW'(best_reg);
                        contrib_reg <= contrib_reg + 1'b1;
                    end
                    i_reg     <= i_reg + step_reg;
                    state_reg <= S_OUTER;
                end
                S_MEAN: state_reg <= S_FRAC;
                S_FRAC: begin
                    if (ddone && !phase_reg) begin
                        q_reg     <= dquo[63:0];
                        phase_reg <= 1'b1;
                    end else if (ddone && phase_reg) begin
                        q_reg      <= {32'd0, q_reg[63:32]};
                        rad_reg    <= {q_reg[31:0], dquo[31:0]};
                        sq_rem_reg <= '0;
                        root_reg   <= '0;
                        sqcnt_reg  <= 7'd64;
                        phase_reg  <= 1'b0;
                        state_reg  <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    // Digit-by-digit root over hi (q_reg then rad_reg) pairs.
                    if (sq_trial >= sq_sub) begin
                        sq_rem_reg <= sq_trial - sq_sub;
                        root_reg   <= {root_reg[38:0], 1'b1};
                    end else begin
                        sq_rem_reg <= sq_trial;
                        root_reg   <= {root_reg[38:0], 1'b0};
                    end
                    q_reg     <= {q_reg[61:0], rad_reg[63:62]};
                    rad_reg   <= {rad_reg[61:0], 2'b00};
                    sqcnt_reg <= sqcnt_reg - 1'b1;
                    if (sqcnt_reg == 7'd1) state_reg <= S_SCALE;
                end
                S_SCALE: begin
                    if (ddone && phase_reg) begin
                        sample_reg <= 13'(contrib_reg);
                        if (dquo[NW-1:48] != '0) begin
                            sigma_reg  <= SIGMA_MAX;
                            status_reg <= ST_OK;
                        end else if (dquo[47:0] > 48'(min_sigma_reg)) begin
                            sigma_reg  <= dquo[47:0];
                            status_reg <= ST_OK;
                        end else begin
                            sigma_reg  <= DEFAULT_SIGMA;
                            status_reg <= ST_THRESHOLD;
                        end
                        phase_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end else begin
                        phase_reg <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid) begin
                        m_tvalid <= 1'b1;
                    end else if (m_tready) begin
                        m_tvalid  <= 1'b0;
                        count_reg <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_tdata = {1'b0, sample_reg, status_reg, sigma_reg};

    `MNNS_ASSERT_IMP(a_ready_idle, aclk, aresetn, m_tvalid, !s_tready,
        "input ready while a result is pending")
    `MNNS_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid,
        "result dropped before it was taken")
    `MNNS_ASSERT_IMP(a_count, aclk, aresetn, 1'b1, count_reg <= NB'(MAX_POINTS),
        "point count beyond store depth")
endmodule
